/* rtl/core/utf8_to_cp850_transcoder_macros.svh */
// ----------------------------------------------------------------------------
// UTF-8 to CP850 transcoder assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CP850_TRANSCODER_MACROS_SVH
`define UTF8_TO_CP850_TRANSCODER_MACROS_SVH

// same-cycle implication, off while in reset
`define U2C_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u2c: same-cycle check failed");

// next-cycle implication, off while in reset
`define U2C_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("u2c: next-cycle check failed");

// next-cycle implication, checked during reset too
`define U2C_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("u2c: reset check failed");

`endif

/* rtl/core/u2c_pkg.sv */
// ----------------------------------------------------------------------------
// u2c_pkg
// Word types, constants and the CP850 upper-half reverse lookup.
// ----------------------------------------------------------------------------
package u2c_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_word;

    localparam logic [7:0] QMARK = 8'h3F;
    localparam logic [7:0] SPACE = 8'h20;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CODE_W = 21;

    localparam logic [15:0] CP850_HI [128] = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00F8, 16'h00A3, 16'h00D8, 16'h00D7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h00AE, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h00C1, 16'h00C2, 16'h00C0,
        16'h00A9, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h00A2, 16'h00A5, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h00E3, 16'h00C3,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h00A4,
        16'h00F0, 16'h00D0, 16'h00CA, 16'h00CB, 16'h00C8, 16'h0131, 16'h00CD, 16'h00CE,
        16'h00CF, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h00A6, 16'h00CC, 16'h2580,
        16'h00D3, 16'h00DF, 16'h00D4, 16'h00D2, 16'h00F5, 16'h00D5, 16'h00B5, 16'h00FE,
        16'h00DE, 16'h00DA, 16'h00DB, 16'h00D9, 16'h00FD, 16'h00DD, 16'h00AF, 16'h00B4,
        16'h00AD, 16'h00B1, 16'h2017, 16'h00BE, 16'h00B6, 16'h00A7, 16'h00F7, 16'h00B8,
        16'h00B0, 16'h00A8, 16'h00B7, 16'h00B9, 16'h00B3, 16'h00B2, 16'h25A0, 16'h00A0
    };

    // code point to CP850 byte; parallel compares against the table
    function automatic logic [7:0] map_code(logic [CODE_W-1:0] code, logic rc);
        logic       hit;
        logic [6:0] idx;
        logic [7:0] r;
        hit = 1'b0;
        idx = 7'd0;
        for (int i = 0; i < 128; i++) begin
            if ({5'd0, CP850_HI[i]} == code) begin
                hit = 1'b1;
                idx = idx | 7'(i);
            end
        end
        if (code[CODE_W-1:7] == '0) begin
            r = code[7:0];
        end else if (hit) begin
            r = {1'b1, idx};
        end else begin
            r = QMARK;
        end
        if (rc && r != 8'd0 && r[7:5] == 3'd0) begin
            r = SPACE;
        end
        return r;
    endfunction

endpackage

/* rtl/core/utf8_to_cp850_transcoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_cp850_transcoder
// UTF-8 byte stream to CP850 byte stream, one input word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_stall carries one UTF-8 byte and an end-of-string
// flag per word. Output channel o_valid/i_stall carries CP850 bytes, with
// out_last on the final byte of each string. i_cfg_we/i_cfg_wdata write the
// replace_controls bit; write it only while the block is idle.
// An accepted word sits in an input register; from there it is decoded
// against the sequence state and its results (zero, one or two) go into a
// four-word output queue once the queue has two free slots. A result leaves
// from the queue head on o_word. Throughput is one input word per cycle while
// the queue has room; a broken sequence gives two result words, which drain
// one per cycle from the queue while the receiver does not stall.
// When the receiver stalls the queue fills; the input register holds while
// the queue has fewer than two free slots, and o_stall rises.
// Synchronous reset clears the sequence state, the queue, the input stage
// and replace_controls.
// ----------------------------------------------------------------------------
module utf8_to_cp850_transcoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  u2c_pkg::t_in_word   i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output u2c_pkg::t_out_word  o_word,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);
    import u2c_pkg::*;

    logic                r_rc;
    logic                r_in_valid;
    t_in_word            r_in_word;
    logic [CODE_W-1:0]   r_acc;
    logic [1:0]          r_rem;
    t_out_word           r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr;
    logic [FIFO_AW-1:0]  r_rd_ptr;
    logic [FIFO_AW:0]    r_count;

    logic [CODE_W-1:0]   n_acc;
    logic [1:0]          n_rem;
    logic [FIFO_AW-1:0]  n_wr_ptr;
    logic [FIFO_AW-1:0]  n_rd_ptr;
    logic [FIFO_AW:0]    n_count;

    logic                advance;
    logic                pop;
    logic [1:0]          push_n;

    logic [7:0]          b;
    logic                l;
    logic                cont;
    logic [CODE_W-1:0]   acc_sh;
    logic [1:0]          rem_dec;

    logic                lead_v;
    t_out_word           lead_word;
    logic [CODE_W-1:0]   lead_acc;
    logic [1:0]          lead_rem;

    logic                res0_v;
    logic                res1_v;
    t_out_word           res0;
    t_out_word           res1;

    assign advance = r_in_valid && (r_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign o_stall = r_in_valid && !advance;
    assign o_valid = (r_count != '0);
    assign o_word  = r_fifo[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    assign b       = r_in_word.in_byte;
    assign l       = r_in_word.in_last;
    assign cont    = (b[7:6] == 2'b10);
    assign acc_sh  = {r_acc[CODE_W-7:0], b[5:0]};
    assign rem_dec = r_rem - 2'd1;

    // lead byte decode
    always_comb begin
        lead_v    = 1'b1;
        lead_word = '{out_byte: QMARK, out_last: l};
        lead_acc  = '0;
        lead_rem  = 2'd0;
        if (!b[7]) begin
            lead_word.out_byte = map_code({13'd0, b}, r_rc);
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            // a lead that ends the string gives '?' with last set (default)
            if (!l) begin
                lead_v = 1'b0;
                if (b[7:5] == 3'b110) begin
                    lead_acc = {16'd0, b[4:0]};
                    lead_rem = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    lead_acc = {17'd0, b[3:0]};
                    lead_rem = 2'd2;
                end else begin
                    lead_acc = {18'd0, b[2:0]};
                    lead_rem = 2'd3;
                end
            end
        end
    end

    // sequence step
    always_comb begin
        res0_v = 1'b0;
        res1_v = 1'b0;
        res0   = '{out_byte: QMARK, out_last: 1'b0};
        res1   = lead_word;
        n_acc  = r_acc;
        n_rem  = r_rem;
        if (r_rem == 2'd0) begin
            res0_v = lead_v;
            res0   = lead_word;
            n_acc  = lead_acc;
            n_rem  = lead_rem;
        end else if (cont) begin
            if (rem_dec == 2'd0) begin
                res0_v = 1'b1;
                res0   = '{out_byte: map_code(acc_sh, r_rc), out_last: l};
                n_acc  = '0;
                n_rem  = 2'd0;
            end else if (l) begin
                res0_v = 1'b1;
                res0   = '{out_byte: QMARK, out_last: 1'b1};
                n_acc  = '0;
                n_rem  = 2'd0;
            end else begin
                n_acc  = acc_sh;
                n_rem  = rem_dec;
            end
        end else begin
            // broken sequence: '?' then the byte again as a lead
            res0_v = 1'b1;
            res1_v = lead_v;
            n_acc  = lead_acc;
            n_rem  = lead_rem;
        end
    end

    assign push_n   = advance ? ({1'b0, res0_v} + {1'b0, res1_v}) : 2'd0;
    assign n_wr_ptr = r_wr_ptr + FIFO_AW'(push_n);
    assign n_rd_ptr = r_rd_ptr + FIFO_AW'(pop);
    assign n_count  = r_count + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc       <= 1'b0;
            r_in_valid <= 1'b0;
            r_acc      <= '0;
            r_rem      <= 2'd0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rc <= i_cfg_wdata;
            end
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_acc <= n_acc;
                r_rem <= n_rem;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_word <= i_word;
        end
        if (advance && res0_v) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (advance && res1_v) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= res1;
        end
    end

endmodule

/* rtl/core/u2c_checker.sv */
// ----------------------------------------------------------------------------
// u2c_checker
// Port-level checks for the UTF-8 to CP850 transcoder, bound to the top.
// ----------------------------------------------------------------------------
`include "utf8_to_cp850_transcoder_macros.svh"

module u2c_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_stall,
    input  logic                o_valid,
    input  logic                i_stall,
    input  u2c_pkg::t_out_word  o_word
);

    // a stalled output word holds
    `U2C_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_word))

    // input back-pressure only comes from a nearly full queue
    `U2C_ASSERT_SAME(a_stall_needs_data, i_clk, i_rst_n, o_stall, o_valid)

    // reset empties both the input stage and the queue
    `U2C_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_valid && !o_stall)

endmodule

bind utf8_to_cp850_transcoder u2c_checker u_u2c_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_word  (o_word)
);

/* bench/utf8_to_cp850_transcoder_tb.sv */
// ----------------------------------------------------------------------------
// utf8_to_cp850_transcoder_tb
// Self-checking bench for the UTF-8 to CP850 transcoder. A directed set
// covers field extremes, stray lead bytes, broken and truncated sequences,
// table hits and misses and control replacement. Random strings follow,
// mostly well-formed UTF-8 with noise mixed in. Both sides idle at random,
// with one idle-free stretch and one long output hold-off. A scoreboard
// predicts every CP850 word and checks the output stream in order.
// ----------------------------------------------------------------------------
module utf8_to_cp850_transcoder_tb;
    import u2c_pkg::t_in_word;
    import u2c_pkg::t_out_word;

    localparam logic [7:0] QUESTION = 8'h3F;
    localparam logic [7:0] BLANK    = 8'h20;
    localparam int         IDLE_LIMIT = 2000;

    localparam logic [15:0] UPPER_HALF [128] = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00F8, 16'h00A3, 16'h00D8, 16'h00D7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h00AE, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h00C1, 16'h00C2, 16'h00C0,
        16'h00A9, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h00A2, 16'h00A5, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h00E3, 16'h00C3,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h00A4,
        16'h00F0, 16'h00D0, 16'h00CA, 16'h00CB, 16'h00C8, 16'h0131, 16'h00CD, 16'h00CE,
        16'h00CF, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h00A6, 16'h00CC, 16'h2580,
        16'h00D3, 16'h00DF, 16'h00D4, 16'h00D2, 16'h00F5, 16'h00D5, 16'h00B5, 16'h00FE,
        16'h00DE, 16'h00DA, 16'h00DB, 16'h00D9, 16'h00FD, 16'h00DD, 16'h00AF, 16'h00B4,
        16'h00AD, 16'h00B1, 16'h2017, 16'h00BE, 16'h00B6, 16'h00A7, 16'h00F7, 16'h00B8,
        16'h00B0, 16'h00A8, 16'h00B7, 16'h00B9, 16'h00B3, 16'h00B2, 16'h25A0, 16'h00A0
    };

    class cp850_checker;
        logic [20:0] code_acc;
        logic [1:0]  cont_left;
        logic        replace_ctl;
        t_out_word   cp850_due[$];
        int          errors;

        function new();
            code_acc    = '0;
            cont_left   = '0;
            replace_ctl = 1'b0;
            errors      = 0;
        endfunction

        function logic [7:0] lookup_cp850(logic [20:0] cp);
            logic [7:0] r;
            logic       found;
            r     = QUESTION;
            found = 1'b0;
            if (cp < 21'd128) begin
                r = cp[7:0];
            end else begin
                for (int i = 0; i < 128; i++) begin
                    if (!found && {5'd0, UPPER_HALF[i]} == cp) begin
                        r     = 8'(128 + i);
                        found = 1'b1;
                    end
                end
            end
            if (replace_ctl && r != 8'd0 && r < 8'd32) begin
                r = BLANK;
            end
            return r;
        endfunction

        function void push_due(logic [7:0] b, logic last);
            t_out_word w;
            w.out_byte = b;
            w.out_last = last;
            cp850_due.push_back(w);
        endfunction

        function void start_sequence(logic [7:0] b, logic last);
            logic opened;
            opened = 1'b1;
            if (b[7] == 1'b0) begin
                push_due(lookup_cp850({13'd0, b}), last);
                opened = 1'b0;
            end else if (b[7:5] == 3'b110) begin
                code_acc  = {16'd0, b[4:0]};
                cont_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                code_acc  = {17'd0, b[3:0]};
                cont_left = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                code_acc  = {18'd0, b[2:0]};
                cont_left = 2'd3;
            end else begin
                push_due(QUESTION, last);
                opened = 1'b0;
            end
            if (opened && last) begin
                code_acc  = '0;
                cont_left = '0;
                push_due(QUESTION, 1'b1);
            end
        endfunction

        function void note_utf8(t_in_word w);
            logic [7:0] b;
            logic       last;
            b    = w.in_byte;
            last = w.in_last;
            if (cont_left == 2'd0) begin
                start_sequence(b, last);
            end else if (b[7:6] == 2'b10) begin
                code_acc  = {code_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    push_due(lookup_cp850(code_acc), last);
                    code_acc = '0;
                end else if (last) begin
                    push_due(QUESTION, 1'b1);
                    code_acc  = '0;
                    cont_left = '0;
                end
            end else begin
                code_acc  = '0;
                cont_left = '0;
                push_due(QUESTION, 1'b0);
                start_sequence(b, last);
            end
        endfunction

        function void check_cp850(t_out_word got);
            t_out_word want;
            if (cp850_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none, actual byte %h last %b",
                         $time, got.out_byte, got.out_last);
            end else begin
                want = cp850_due.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    errors++;
                    $display("%0t: out_byte mismatch: expected %h, actual %h",
                             $time, want.out_byte, got.out_byte);
                end
                if (got.out_last !== want.out_last) begin
                    errors++;
                    $display("%0t: out_last mismatch: expected %b, actual %b",
                             $time, want.out_last, got.out_last);
                end
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_word;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_word;
    logic      i_cfg_we;
    logic      i_cfg_wdata;

    cp850_checker cp850_chk;
    int           words_sent;
    int           idle_cycles = 0;
    int           hold_req;
    bit           calm;
    logic [7:0]   str_bytes[$];

    utf8_to_cp850_transcoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_word     (o_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, idle-free while calm, long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (calm) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 33);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            cp850_chk.check_cp850(o_word);
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic offer_word(logic [7:0] b, logic last);
        t_in_word w;
        w.in_byte = b;
        w.in_last = last;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 33) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_stall);
        cp850_chk.note_utf8(w);
        words_sent++;
    endtask

    task automatic park_and_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (cp850_chk.cp850_due.size() != 0) @(posedge i_clk);
        // a pending lead byte gives no word; let the pipeline settle
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_replace_controls(logic v);
        park_and_drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cp850_chk.replace_ctl = v;
    endtask

    function automatic void push_utf8(logic [20:0] cp, int len);
        case (len)
            1: str_bytes.push_back({1'b0, cp[6:0]});
            2: begin
                str_bytes.push_back({3'b110, cp[10:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            3: begin
                str_bytes.push_back({4'b1110, cp[15:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            default: begin
                str_bytes.push_back({5'b11110, cp[20:18]});
                str_bytes.push_back({2'b10, cp[17:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    task automatic send_random_string();
        int          nchar;
        int          kind;
        int          len;
        int          cut;
        logic [20:0] cp;
        str_bytes.delete();
        nchar = $urandom_range(1, 6);
        for (int c = 0; c < nchar; c++) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                push_utf8(21'($urandom_range(0, 127)), 1);
            end else if (kind < 65) begin
                cp = {5'd0, UPPER_HALF[$urandom_range(0, 127)]};
                push_utf8(cp, (cp < 21'h800) ? 2 : 3);
            end else if (kind < 93) begin
                len = $urandom_range(2, 4);
                cp  = 21'($urandom);
                push_utf8(cp, len);
                if (kind < 75) begin
                    cut = 0;
                end else begin
                    cut = $urandom_range(1, len - 1);
                end
                repeat (cut) void'(str_bytes.pop_back());
            end else if (kind < 96) begin
                str_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 98) begin
                str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end else begin
                str_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
            end
        end
        for (int i = 0; i < str_bytes.size(); i++) begin
            offer_word(str_bytes[i], i == str_bytes.size() - 1);
        end
    endtask

    task automatic run_random(int upto);
        while (words_sent < upto) send_random_string();
    endtask

    initial begin
        cp850_chk   = new();
        words_sent  = 0;
        hold_req    = 0;
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_word      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        offer_word(8'h00, 1'b0);
        offer_word(8'h7F, 1'b1);
        offer_word(8'h80, 1'b0);
        offer_word(8'hFF, 1'b1);
        offer_word(8'hC3, 1'b0);
        offer_word(8'hA9, 1'b1);
        offer_word(8'hE2, 1'b0);
        offer_word(8'h96, 1'b0);
        offer_word(8'h91, 1'b0);
        offer_word(8'hE2, 1'b0);
        offer_word(8'h96, 1'b0);
        offer_word(8'hA0, 1'b0);
        offer_word(8'hF0, 1'b0);
        offer_word(8'h9F, 1'b0);
        offer_word(8'h98, 1'b0);
        offer_word(8'h80, 1'b0);
        offer_word(8'hC3, 1'b0);
        offer_word(8'h41, 1'b0);
        offer_word(8'hE2, 1'b0);
        offer_word(8'h82, 1'b1);
        offer_word(8'hC2, 1'b0);
        offer_word(8'hA0, 1'b1);
        offer_word(8'hC3, 1'b1);

        set_replace_controls(1'b1);
        offer_word(8'h01, 1'b0);
        offer_word(8'hC3, 1'b0);
        offer_word(8'h1F, 1'b0);
        offer_word(8'h00, 1'b1);

        set_replace_controls(1'b0);
        run_random(words_sent + 260);

        // hold the output long enough for the queue to fill and stall input
        set_replace_controls(1'b1);
        hold_req = 150;
        run_random(words_sent + 260);

        set_replace_controls(1'b0);
        calm = 1'b1;
        run_random(words_sent + 150);
        calm = 1'b0;
        run_random(words_sent + 110);

        set_replace_controls(1'b1);
        run_random(words_sent + 270);

        park_and_drain();
        if (cp850_chk.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
